// File: design/dfs_topological_order_defines.svh
// Assertion macros used by the top-level design file.
`ifndef DFS_TOPOLOGICAL_ORDER_DEFINES_SVH
`define DFS_TOPOLOGICAL_ORDER_DEFINES_SVH
// Implication checked at each clock edge, disabled in reset.
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: design/dfs_pkg.sv
// Constants and types for the depth-first topological order block.
package dfs_pkg;
  localparam int MaxNodes = 64;
  localparam int MaxEdges = 256;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int EdgeW = $clog2(MaxEdges);
  localparam int LinkW = EdgeW + 1;
  localparam logic [LinkW-1:0] NullLink = LinkW'(MaxEdges);
  localparam logic OpEdge = 1'b0;
  localparam logic OpRun = 1'b1;
  typedef logic [NodeW-1:0] node_t;
  typedef logic [LinkW-1:0] link_t;
endpackage

// File: design/dfs_topological_order.sv
// Top level: edge store, depth-first walk sequencer and order output.
// Usage: node_count is written on the cfg channel (cfg_valid/cfg_ready,
// cfg_data); cfg_ready is high only while the block is idle. Items arrive on
// in_valid/in_ready with operation, from_node and to_node. operation 0
// stores one edge (a head/tail table read, then the link write); a dropped
// edge is not stored and sets the error flag. operation 1 runs the walk;
// the block is not ready until every result is delivered. The walk scans
// each node as a start, opens and closes every node it reaches and follows
// each stored edge, then gives one result per cycle on out_valid/out_ready
// with order_node, last_node and edge_error. A stalled receiver holds the
// output register and the emit phase waits. After the last result a clearing
// pass resets the head, tail and visited tables. After reset the same pass
// runs before the first item is taken; node_count resets to 64 and the error
// flag to zero.
`include "dfs_topological_order_defines.svh"
module dfs_topological_order import dfs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         operation,
  input  logic [5:0]   from_node,
  input  logic [5:0]   to_node,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [5:0]   order_node,
  output logic         last_node,
  output logic         edge_error
);
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_ADD = 4'd2,
    S_START = 4'd3, S_TOP = 4'd4, S_EDGE = 4'd5, S_DEST = 4'd6,
    S_PUSH = 4'd7, S_EMIT = 4'd8, S_SCHK = 4'd9, S_VIS = 4'd10;

  logic [3:0] state;
  logic [6:0] node_count;
  logic [EdgeW:0] edge_total;
  logic dropped;
  logic [NodeW:0] clr_idx;

  // memories
  logic [NodeW-1:0] dest_mem [MaxEdges];
  link_t link_mem [MaxEdges];
  link_t head_mem [MaxNodes];
  link_t tail_mem [MaxNodes];
  logic [NodeW-1:0] wnode_mem [MaxNodes];
  link_t wcur_mem [MaxNodes];
  logic [NodeW-1:0] fin_mem [MaxNodes];
  logic vis_mem [MaxNodes];

  logic [NodeW:0] n_eff;
  logic [NodeW:0] start, depth, done, emit_k;
  node_t  a_from, top_node, dest;
  link_t  head_rd, tail_rd, cur, nxt;
  logic   vis_rd;

  always_comb begin
    if (node_count == 7'd0) n_eff = (NodeW+1)'(1);
    else if (node_count > 7'(MaxNodes)) n_eff = (NodeW+1)'(MaxNodes);
    else n_eff = node_count[NodeW:0];
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) node_count <= 7'd64;
    else if (cfg_valid && cfg_ready) node_count <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_idx <= '0; edge_total <= '0; dropped <= 1'b0;
      out_valid <= 1'b0; start <= '0; depth <= '0;
      done <= '0; emit_k <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          head_mem[clr_idx[NodeW-1:0]] <= NullLink;
          tail_mem[clr_idx[NodeW-1:0]] <= NullLink;
          vis_mem[clr_idx[NodeW-1:0]] <= 1'b0;
          edge_total <= '0;
          if (clr_idx == (NodeW+1)'(MaxNodes-1)) begin
            state <= S_IDLE; clr_idx <= '0;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        S_IDLE: if (in_valid) begin
          if (operation == OpRun) begin
            start <= '0; done <= '0; state <= S_START;
          end else if ({1'b0, from_node} >= n_eff || {1'b0, to_node} >= n_eff
                       || edge_total >= (EdgeW+1)'(MaxEdges)) begin
            dropped <= 1'b1;
          end else begin
            // new edge goes to the end of its list
            dest_mem[edge_total[EdgeW-1:0]] <= to_node;
            link_mem[edge_total[EdgeW-1:0]] <= NullLink;
            a_from <= from_node;
            head_rd <= head_mem[from_node]; tail_rd <= tail_mem[from_node];
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (head_rd == NullLink) begin
            head_mem[a_from] <= LinkW'(edge_total);
          end else begin
            link_mem[tail_rd[EdgeW-1:0]] <= LinkW'(edge_total);
          end
          tail_mem[a_from] <= LinkW'(edge_total);
          edge_total <= edge_total + 1'b1;
          state <= S_IDLE;
        end
        S_START: begin
          if (start == n_eff) begin
            emit_k <= '0; state <= S_EMIT;
          end else begin
            vis_rd <= vis_mem[start[NodeW-1:0]];
            head_rd <= head_mem[start[NodeW-1:0]];
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (vis_rd) begin
            start <= start + 1'b1; state <= S_START;
          end else begin
            vis_mem[start[NodeW-1:0]] <= 1'b1;
            dest <= start[NodeW-1:0];
            depth <= '0;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          wnode_mem[depth[NodeW-1:0]] <= dest;
          wcur_mem[depth[NodeW-1:0]] <= head_rd;
          depth <= depth + 1'b1;
          state <= S_TOP;
        end
        S_TOP: begin
          if (depth == '0) begin
            start <= start + 1'b1; state <= S_START;
          end else begin
            top_node <= wnode_mem[depth[NodeW-1:0] - 1'b1];
            cur <= wcur_mem[depth[NodeW-1:0] - 1'b1];
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (cur == NullLink) begin
            if (done < (NodeW+1)'(MaxNodes)) begin
              fin_mem[done[NodeW-1:0]] <= top_node;
              done <= done + 1'b1;
            end
            depth <= depth - 1'b1;
            state <= S_TOP;
          end else begin
            nxt <= link_mem[cur[EdgeW-1:0]];
            dest <= dest_mem[cur[EdgeW-1:0]];
            state <= S_VIS;
          end
        end
        S_VIS: begin
          // advance the cursor and fetch the destination's mark and list head
          wcur_mem[depth[NodeW-1:0] - 1'b1] <= nxt;
          vis_rd <= vis_mem[dest];
          head_rd <= head_mem[dest];
          state <= S_DEST;
        end
        S_DEST: begin
          if ({1'b0, dest} < n_eff && !vis_rd &&
              depth < (NodeW+1)'(MaxNodes)) begin
            vis_mem[dest] <= 1'b1;
            state <= S_PUSH;
          end else begin
            state <= S_TOP;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            if (emit_k == done) begin
              out_valid <= 1'b0;
              dropped <= 1'b0; clr_idx <= '0; state <= S_CLR;
            end else begin
              out_valid <= 1'b1;
              order_node <= fin_mem[done[NodeW-1:0] - emit_k[NodeW-1:0] - 1'b1];
              last_node <= (emit_k + 1'b1 == done);
              edge_error <= dropped;
              emit_k <= emit_k + 1'b1;
            end
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  `ASSERT_IMPL(a_out_only_emit, clk, rst, out_valid, state == S_EMIT)
  `ASSERT_IMPL(a_depth_bound, clk, rst, 1'b1, depth <= (NodeW+1)'(MaxNodes))
  `ASSERT_NEXT(a_add_returns, clk, rst, state == S_ADD, state == S_IDLE)
endmodule
